/* src/ccts_pkg.sv */
package ccts_pkg;

	// Default screen geometry
	localparam int DEF_ROWS = 10;
	localparam int DEF_COLS = 10;

	// Item opcodes
	localparam logic [1:0] OP_FEED = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_NEW  = 2'd2;

	// Characters the parser knows
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_U     = 8'h75;

	// Screen array operations
	typedef enum logic [1:0] {
		SCR_NONE  = 2'd0,
		SCR_WRITE = 2'd1,
		SCR_ERASE = 2'd2,
		SCR_CLEAR = 2'd3
	} scr_op_t;

	// Command from the parser to the screen array
	typedef struct packed {
		scr_op_t    op;
		logic       ins;
		logic [7:0] ch;
	} scr_cmd_t;

endpackage

/* src/caret_control_text_screen.sv */
// Caret-controlled text screen. Takes one item per clock cycle: feed a text
// byte, read a cell, or start a new screen. Every item updates the screen
// cells, cursor and escape parser in the cycle it is accepted, so the next
// item can follow at once. A read item produces one result in the output
// register the cycle after acceptance; it holds the cell as it stood after
// all earlier items, plus the cursor and mode. req_ready drops only while a
// result waits in the output register and rsp_ready is low. After reset the
// screen is all spaces, cursor home, overwrite mode, with no clearing pass.
module caret_control_text_screen import ccts_pkg::*; #(
	parameter int ROWS = DEF_ROWS,
	parameter int COLS = DEF_COLS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [1:0] opcode,
	input  logic [7:0] char_byte,
	input  logic       line_end,
	input  logic [3:0] read_row,
	input  logic [3:0] read_col,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic [7:0] cell_char,
	output logic [3:0] cursor_row,
	output logic [3:0] cursor_col,
	output logic       insert_on
);

	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLS);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_CARET = 3'b010,
		PH_DIGIT = 3'b100
	} phase_t;

	logic [RW-1:0] cur_y_q, cur_y_n;
	logic [CW-1:0] cur_x_q, cur_x_n;
	logic          ins_q, ins_n;
	phase_t        phase_q, phase_n;
	logic [3:0]    held_q, held_n;

	logic          rsp_valid_q;
	logic [7:0]    cell_char_q;
	logic [3:0]    cursor_row_q;
	logic [3:0]    cursor_col_q;
	logic          insert_on_q;

	logic          acc;
	logic          is_digit;
	logic          do_put;
	logic [7:0]    put_char;
	logic [RW-1:0] row_sat;
	logic [CW-1:0] col_sat;
	scr_cmd_t      cmd;
	logic [7:0]    read_char;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign acc       = req_valid && req_ready;

	// Digit test and saturated move targets
	always_comb begin
		is_digit = char_byte inside {[CH_0:CH_9]};
		row_sat  = (held_q > 4'(ROWS - 1)) ? RW'(ROWS - 1) : held_q[RW-1:0];
		col_sat  = (char_byte[3:0] > 4'(COLS - 1)) ? CW'(COLS - 1) : char_byte[CW-1:0];
	end

	// Escape parser and cursor update
	always_comb begin
		cur_y_n  = cur_y_q;
		cur_x_n  = cur_x_q;
		ins_n    = ins_q;
		phase_n  = phase_q;
		held_n   = held_q;
		do_put   = 1'b0;
		put_char = char_byte;
		cmd.op   = SCR_NONE;
		cmd.ins  = ins_q;
		cmd.ch   = char_byte;

		if (acc && opcode == OP_FEED) begin
			phase_n = PH_IDLE;
			case (phase_q)
				PH_CARET: begin
					if (is_digit) begin
						if (!line_end) begin
							held_n  = char_byte[3:0];
							phase_n = PH_DIGIT;
						end
					end else begin
						case (char_byte)
							CH_B: cur_x_n = '0;
							CH_C: cmd.op = SCR_CLEAR;
							CH_E: cmd.op = SCR_ERASE;
							CH_H: begin
								cur_y_n = '0;
								cur_x_n = '0;
							end
							CH_I: ins_n = 1'b1;
							CH_O: ins_n = 1'b0;
							CH_D: if (cur_y_q != RW'(ROWS - 1)) cur_y_n = cur_y_q + RW'(1);
							CH_U: if (cur_y_q != '0) cur_y_n = cur_y_q - RW'(1);
							CH_L: if (cur_x_q != '0) cur_x_n = cur_x_q - CW'(1);
							CH_R: if (cur_x_q != CW'(COLS - 1)) cur_x_n = cur_x_q + CW'(1);
							CH_CARET: do_put = 1'b1;
							default: ;
						endcase
					end
				end
				PH_DIGIT: begin
					if (is_digit) begin
						cur_y_n = row_sat;
						cur_x_n = col_sat;
					end else if (char_byte == CH_CARET) begin
						phase_n = PH_CARET;
					end else begin
						do_put = 1'b1;
					end
				end
				default: begin
					if (char_byte == CH_CARET)
						phase_n = PH_CARET;
					else
						do_put = 1'b1;
				end
			endcase

			// plain write at the cursor, cursor stops at the last column
			if (do_put) begin
				cmd.op = SCR_WRITE;
				cmd.ch = put_char;
				if (cur_x_q != CW'(COLS - 1))
					cur_x_n = cur_x_q + CW'(1);
			end

			if (line_end)
				phase_n = PH_IDLE;
		end else if (acc && opcode == OP_NEW) begin
			cmd.op  = SCR_CLEAR;
			cur_y_n = '0;
			cur_x_n = '0;
			ins_n   = 1'b0;
			phase_n = PH_IDLE;
			held_n  = '0;
		end
	end

	ccts_screen #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_screen (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_row  (cur_y_q),
		.cmd_col  (cur_x_q),
		.read_row (read_row),
		.read_col (read_col),
		.read_char(read_char)
	);

	// Parser and cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_y_q <= '0;
			cur_x_q <= '0;
			ins_q   <= 1'b0;
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else begin
			cur_y_q <= cur_y_n;
			cur_x_q <= cur_x_n;
			ins_q   <= ins_n;
			phase_q <= phase_n;
			held_q  <= held_n;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (acc && opcode == OP_READ) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (acc && opcode == OP_READ) begin
			cell_char_q  <= read_char;
			cursor_row_q <= 4'(cur_y_q);
			cursor_col_q <= 4'(cur_x_q);
			insert_on_q  <= ins_q;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign cell_char  = cell_char_q;
	assign cursor_row = cursor_row_q;
	assign cursor_col = cursor_col_q;
	assign insert_on  = insert_on_q;

endmodule

/* src/ccts_screen.sv */
module ccts_screen import ccts_pkg::*; #(
	parameter int ROWS = DEF_ROWS,
	parameter int COLS = DEF_COLS,
	localparam int RW = $clog2(ROWS),
	localparam int CW = $clog2(COLS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  scr_cmd_t      cmd,
	input  logic [RW-1:0] cmd_row,
	input  logic [CW-1:0] cmd_col,
	input  logic [3:0]    read_row,
	input  logic [3:0]    read_col,
	output logic [7:0]    read_char
);

	logic [7:0] cells_q [ROWS][COLS];
	logic [7:0] left_w  [ROWS][COLS];

	// One register per cell, each with its own update logic
	for (genvar r = 0; r < ROWS; r++) begin : g_row
		for (genvar c = 0; c < COLS; c++) begin : g_col
			logic on_row;
			logic at_col;
			logic past_col;

			// left neighbor feeds the insert shift
			if (c == 0) begin : g_edge
				assign left_w[r][c] = cells_q[r][c];
			end else begin : g_inner
				assign left_w[r][c] = cells_q[r][c-1];
			end

			assign on_row   = (cmd_row == RW'(r));
			assign at_col   = (cmd_col == CW'(c));
			assign past_col = (CW'(c) > cmd_col);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cells_q[r][c] <= CH_SPACE;
				end else begin
					case (cmd.op)
						SCR_CLEAR: cells_q[r][c] <= CH_SPACE;
						SCR_ERASE: begin
							if (on_row && (at_col || past_col))
								cells_q[r][c] <= CH_SPACE;
						end
						SCR_WRITE: begin
							if (on_row && at_col)
								cells_q[r][c] <= cmd.ch;
							else if (on_row && past_col && cmd.ins)
								cells_q[r][c] <= left_w[r][c];
						end
						default: ;
					endcase
				end
			end
		end
	end

	// Read port, zero outside the screen
	always_comb begin
		if (read_row < 4'(ROWS) && read_col < 4'(COLS))
			read_char = cells_q[read_row[RW-1:0]][read_col[CW-1:0]];
		else
			read_char = '0;
	end

endmodule

/* src/ccts_checker.sv */
module ccts_checker import ccts_pkg::*; #(
	parameter int ROWS = DEF_ROWS,
	parameter int COLS = DEF_COLS
) (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic [1:0] opcode,
	input logic [3:0] read_row,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] cell_char,
	input logic [3:0] cursor_row,
	input logic [3:0] cursor_col,
	input logic       insert_on
);

	// A stalled result holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(cell_char)
			&& $stable(cursor_row) && $stable(cursor_col) && $stable(insert_on))
		else $error("stalled result changed");

	// Every accepted read gives a result in the next cycle
	a_read_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && opcode == OP_READ |=> rsp_valid)
		else $error("read item gave no result");

	// Other items give no result
	a_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && opcode != OP_READ |=> !rsp_valid)
		else $error("result without read item");

	// Reads beyond the last row return zero
	a_oob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && opcode == OP_READ && read_row >= 4'(ROWS)
			|=> cell_char == 8'h00)
		else $error("out of range read not zero");

	// Reported cursor stays on the screen
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> cursor_row < 4'(ROWS) && cursor_col < 4'(COLS))
		else $error("cursor off screen");

endmodule

bind caret_control_text_screen ccts_checker #(
	.ROWS(ROWS),
	.COLS(COLS)
) u_ccts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.opcode    (opcode),
	.read_row  (read_row),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.cell_char (cell_char),
	.cursor_row(cursor_row),
	.cursor_col(cursor_col),
	.insert_on (insert_on)
);

/* sim/screen_checker.sv */
// Watches both channels of the caret text screen, keeps its own copy of the
// screen, cursor, mode and escape parser, and checks every read result
// against the cell, cursor and mode predicted for it.
module screen_checker import ccts_pkg::*; #(
	parameter int ROWS = DEF_ROWS,
	parameter int COLS = DEF_COLS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_ready,
	input  logic [1:0] opcode,
	input  logic [7:0] char_byte,
	input  logic       line_end,
	input  logic [3:0] read_row,
	input  logic [3:0] read_col,
	input  logic       rsp_valid,
	input  logic       rsp_ready,
	input  logic [7:0] cell_char,
	input  logic [3:0] cursor_row,
	input  logic [3:0] cursor_col,
	input  logic       insert_on,
	output int         mismatches,
	output int         awaiting
);

	// Escape parser position
	typedef enum logic [1:0] {
		ESC_IDLE  = 2'd0,
		ESC_CARET = 2'd1,
		ESC_DIGIT = 2'd2
	} esc_state_t;

	// What a read item should return
	typedef struct packed {
		logic [7:0] ch;
		logic [3:0] row;
		logic [3:0] col;
		logic       ins;
	} cell_read_t;

	cell_read_t reads_due[$];

	logic [7:0] cells [ROWS*COLS];
	logic [3:0] cur_y;
	logic [3:0] cur_x;
	logic       ins_mode;
	esc_state_t esc;
	logic [3:0] held;
	int         err_total = 0;

	task report_mismatch(input string msg);
		if (err_total < 100)
			$display("screen_checker: %s", msg);
		err_total++;
	endtask

	task blank_cells();
		for (int k = 0; k < ROWS*COLS; k++)
			cells[k] = CH_SPACE;
	endtask

	task new_screen();
		blank_cells();
		cur_y = '0;
		cur_x = '0;
		ins_mode = 1'b0;
		esc = ESC_IDLE;
		held = '0;
	endtask

	// Write at the cursor; insert mode pushes the row right, losing its end
	task write_char(input logic [7:0] b);
		int base;
		base = cur_y * COLS;
		if (ins_mode)
			for (int k = COLS - 1; k > cur_x; k--)
				cells[base + k] = cells[base + k - 1];
		cells[base + cur_x] = b;
		if (cur_x < COLS - 1)
			cur_x++;
	endtask

	// Byte following a lone caret
	task run_letter(input logic [7:0] b);
		case (b)
			CH_B: cur_x = '0;
			CH_C: blank_cells();
			CH_E: begin
				for (int k = cur_x; k < COLS; k++)
					cells[cur_y * COLS + k] = CH_SPACE;
			end
			CH_H: begin
				cur_y = '0;
				cur_x = '0;
			end
			CH_I: ins_mode = 1'b1;
			CH_O: ins_mode = 1'b0;
			CH_D: if (cur_y < ROWS - 1) cur_y++;
			CH_U: if (cur_y > 0) cur_y--;
			CH_L: if (cur_x > 0) cur_x--;
			CH_R: if (cur_x < COLS - 1) cur_x++;
			CH_CARET: write_char(CH_CARET);
			default: ;
		endcase
	endtask

	task plain_or_caret(input logic [7:0] b);
		if (b == CH_CARET)
			esc = ESC_CARET;
		else
			write_char(b);
	endtask

	task take_byte(input logic [7:0] b, input logic last);
		int r, c;
		case (esc)
			ESC_CARET: begin
				esc = ESC_IDLE;
				if (b >= CH_0 && b <= CH_9) begin
					if (!last) begin
						held = 4'(b - CH_0);
						esc = ESC_DIGIT;
					end
				end else begin
					run_letter(b);
				end
			end
			ESC_DIGIT: begin
				esc = ESC_IDLE;
				if (b >= CH_0 && b <= CH_9) begin
					r = held;
					c = b - CH_0;
					cur_y = 4'(r > ROWS - 1 ? ROWS - 1 : r);
					cur_x = 4'(c > COLS - 1 ? COLS - 1 : c);
				end else begin
					plain_or_caret(b);
				end
			end
			default: begin
				esc = ESC_IDLE;
				plain_or_caret(b);
			end
		endcase
		// escapes never span lines
		if (last)
			esc = ESC_IDLE;
	endtask

	// Results are compared before the same edge's item is applied
	always @(posedge clk or negedge arst_n) begin
		cell_read_t got, want;
		logic [7:0] ch;
		if (!arst_n) begin
			new_screen();
			reads_due.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				got = {cell_char, cursor_row, cursor_col, insert_on};
				if (reads_due.size() == 0) begin
					report_mismatch($sformatf("result %h with no read pending", got));
				end else begin
					want = reads_due.pop_front();
					if (got.ch !== want.ch)
						report_mismatch($sformatf("cell_char want %h got %h",
							want.ch, got.ch));
					if (got.row !== want.row)
						report_mismatch($sformatf("cursor_row want %0d got %0d",
							want.row, got.row));
					if (got.col !== want.col)
						report_mismatch($sformatf("cursor_col want %0d got %0d",
							want.col, got.col));
					if (got.ins !== want.ins)
						report_mismatch($sformatf("insert_on want %b got %b",
							want.ins, got.ins));
				end
			end
			if (req_valid && req_ready) begin
				case (opcode)
					OP_FEED: take_byte(char_byte, line_end);
					OP_NEW:  new_screen();
					OP_READ: begin
						if (read_row < ROWS && read_col < COLS)
							ch = cells[read_row * COLS + read_col];
						else
							ch = 8'h00;
						reads_due.push_back({ch, cur_y, cur_x, ins_mode});
					end
					default: ;
				endcase
			end
		end
		mismatches <= err_total;
		awaiting <= reads_due.size();
	end

endmodule

/* sim/tb_top.sv */
module tb_top;
	import ccts_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1000;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 10;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	logic [1:0] opcode    = OP_FEED;
	logic [7:0] char_byte = 8'h00;
	logic       line_end  = 1'b0;
	logic [3:0] read_row  = 4'h0;
	logic [3:0] read_col  = 4'h0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	logic [7:0] cell_char;
	logic [3:0] cursor_row;
	logic [3:0] cursor_col;
	logic       insert_on;

	int fail_count;
	int reads_waiting;
	int items_sent     = 0;
	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	caret_control_text_screen dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.opcode     (opcode),
		.char_byte  (char_byte),
		.line_end   (line_end),
		.read_row   (read_row),
		.read_col   (read_col),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.cell_char  (cell_char),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.insert_on  (insert_on)
	);

	screen_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.opcode     (opcode),
		.char_byte  (char_byte),
		.line_end   (line_end),
		.read_row   (read_row),
		.read_col   (read_col),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.cell_char  (cell_char),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.insert_on  (insert_on),
		.mismatches (fail_count),
		.awaiting   (reads_waiting)
	);

	always #1 clk = ~clk;

	// Result side back-pressure
	always @(posedge clk)
		rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// Present one item and hold it until accepted
	task send_item(input logic [1:0] op, input logic [7:0] b, input logic last,
			input logic [3:0] rr, input logic [3:0] rc);
		// idling pattern rotates every 120 items
		case ((items_sent / 120) % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 83;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 83;
			end
			default: begin
				send_idle_pct = 27;
				recv_stall_pct = 27;
			end
		endcase
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		opcode <= op;
		char_byte <= b;
		line_end <= last;
		read_row <= rr;
		read_col <= rc;
		do @(posedge clk); while (!req_ready);
		items_sent++;
	endtask

	task feed_byte(input logic [7:0] b, input logic last);
		send_item(OP_FEED, b, last, 4'($urandom), 4'($urandom));
	endtask

	task read_cell(input logic [3:0] rr, input logic [3:0] rc);
		send_item(OP_READ, 8'($urandom), 1'($urandom), rr, rc);
	endtask

	task feed_text(input string s, input bit ends_line);
		for (int i = 0; i < s.len(); i++)
			feed_byte(s[i], ends_line && i == s.len() - 1);
	endtask

	initial begin
		int n0, pick;
		logic [7:0] letter;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, every operation, parser corner cases
		read_cell(4'd0, 4'd0);
		feed_byte(8'h00, 1'b0);
		feed_byte(8'hFF, 1'b0);
		feed_text("^99Z", 1'b0);          // jump to last cell, write, cursor pinned
		read_cell(4'd9, 4'd9);
		feed_text("^i^bQ", 1'b0);         // insert at row start shifts the row
		read_cell(4'd9, 4'd1);
		feed_text("^e", 1'b0);            // erase rest of row
		feed_text("^5x", 1'b0);           // lone digit dropped, x taken as text
		feed_text("^7", 1'b1);            // digit ending its line
		feed_text("^", 1'b1);             // caret ending its line
		feed_text("^^^z", 1'b0);          // doubled caret, unknown letter
		read_cell(4'd9, 4'd3);
		send_item(OP_UNUSED, 8'hFF, 1'b1, 4'hF, 4'hF);
		read_cell(4'hF, 4'hF);
		read_cell(4'hA, 4'h3);
		send_item(OP_NEW, 8'h00, 1'b0, 4'h0, 4'h0);

		// Random: mostly well-formed escapes and text, some noise
		n0 = items_sent;
		while (items_sent - n0 < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 28) begin
				if ($urandom_range(9) == 0)
					read_cell(4'($urandom), 4'($urandom));
				else
					read_cell(4'($urandom_range(9)), 4'($urandom_range(9)));
			end else if (pick < 58) begin
				feed_byte(CH_CARET, 1'b0);
				pick = $urandom_range(9);
				if (pick < 4) begin
					feed_byte(CH_0 + 8'($urandom_range(9)), 1'b0);
					feed_byte(CH_0 + 8'($urandom_range(9)), $urandom_range(9) == 0);
				end else if (pick < 9) begin
					case ($urandom_range(9))
						0: letter = CH_B;
						1: letter = CH_C;
						2: letter = CH_E;
						3: letter = CH_H;
						4: letter = CH_I;
						5: letter = CH_O;
						6: letter = CH_D;
						7: letter = CH_U;
						8: letter = CH_L;
						default: letter = CH_R;
					endcase
					feed_byte(letter, $urandom_range(7) == 0);
				end else begin
					feed_byte(CH_CARET, $urandom_range(7) == 0);
				end
			end else if (pick < 83) begin
				feed_byte(8'($urandom_range(126, 32)), $urandom_range(7) == 0);
			end else if (pick < 93) begin
				feed_byte(8'($urandom), 1'($urandom));
			end else if (pick < 97) begin
				// broken escapes: cut by line end or a non-digit
				feed_byte(CH_CARET, $urandom_range(3) == 0);
				if ($urandom_range(1)) begin
					feed_byte(CH_0 + 8'($urandom_range(9)), 1'b1);
				end else begin
					feed_byte(CH_0 + 8'($urandom_range(9)), 1'b0);
					feed_byte(8'($urandom_range(126, 58)), $urandom_range(3) == 0);
				end
			end else if (pick < 99) begin
				send_item(OP_NEW, 8'($urandom), 1'($urandom), 4'($urandom), 4'($urandom));
			end else begin
				send_item(OP_UNUSED, 8'($urandom), 1'($urandom), 4'($urandom),
					4'($urandom));
			end
		end
		req_valid <= 1'b0;

		// Drain outstanding reads, then watch for strays
		do @(posedge clk); while (reads_waiting != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
